// ===== rtl/core/esc_pkg.sv =====
// Shared types and constants of the environmental sensor compensation core.
// Used by the top level and by the pipelined divider; depends on nothing.
package esc_pkg;

  typedef enum logic [2:0] {
    CfgTemp      = 3'd0,
    CfgPressLow  = 3'd1,
    CfgPressHigh = 3'd2,
    CfgPressNine = 3'd3,
    CfgHum       = 3'd4
  } cfg_idx_e;

  localparam int unsigned DivBits   = 2;
  localparam int unsigned DivStages = 64 / DivBits;

  typedef struct packed {
    logic signed [20:0] fine_temp;
    logic signed [15:0] temp;
    logic        [16:0] hum;
    logic               zero;
  } side_t;

endpackage

// ===== rtl/core/esc_div.sv =====
// Pipelined signed divider, 64-bit dividend by 31-bit divisor, truncating.
// Depends on esc_pkg for the stage count and the sideband word type.
module esc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [63:0]  num_i,
  input  logic signed [30:0]  den_i,
  input  esc_pkg::side_t      side_i,
  output logic                vld_o,
  output logic        [63:0]  quo_o,
  output esc_pkg::side_t      side_o
);

  localparam int unsigned N = esc_pkg::DivStages;

  logic [N:0]     vld_q;
  logic [30:0]    rem_q  [0:N];
  logic [63:0]    nq_q   [0:N];
  logic [30:0]    d_q    [0:N];
  logic           neg_q  [0:N];
  esc_pkg::side_t side_q [0:N];

  logic           out_vld_q;
  logic [63:0]    quo_q;
  esc_pkg::side_t out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      nq_q[0]   <= num_i[63] ? 64'(-num_i) : 64'(num_i);
      d_q[0]    <= den_i[30] ? 31'(-den_i) : 31'(den_i);
      neg_q[0]  <= num_i[63] ^ den_i[30];
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [30:0] r_d;
    logic [63:0] n_d;

    always_comb begin : p_step
      logic [31:0] t;
      r_d = rem_q[s-1];
      n_d = nq_q[s-1];
      for (int k = 0; k < int'(esc_pkg::DivBits); k++) begin
        t   = {r_d, n_d[63]};
        n_d = {n_d[62:0], 1'b0};
        if (t >= {1'b0, d_q[s-1]}) begin
          t      = t - {1'b0, d_q[s-1]};
          n_d[0] = 1'b1;
        end
        r_d = t[30:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= r_d;
        nq_q[s]   <= n_d;
        d_q[s]    <= d_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q      <= neg_q[N] ? 64'(-nq_q[N]) : nq_q[N];
      out_side_q <= side_q[N];
    end
  end

  assign vld_o  = out_vld_q;
  assign quo_o  = quo_q;
  assign side_o = out_side_q;

endmodule

// ===== rtl/core/env_sensor_compensation.sv =====
// 49 register stages; the 32-stage divider (2 quotient bits a stage) sets the depth.
// Throughput: one word per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline; no word is lost or repeated.
// Reset clears all coefficient registers to zero and empties the pipeline.
// Top level of the environmental sensor compensation core.
// Depends on esc_pkg and esc_div.
module env_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // fine_temp[20:0], temp_hundredths[36:21],
                                     // press_q24_8[68:37], hum_q22_10[85:69]
);

  localparam logic signed [63:0] HumLimit   = 64'sd419430400;
  localparam logic signed [63:0] PressLimit = 64'sd4294967295;

  function automatic logic signed [20:0] sat_ft(input logic signed [37:0] v);
    if (v < -38'sd1048576) return -21'sd1048576;
    if (v > 38'sd1048575) return 21'sd1048575;
    return v[20:0];
  endfunction

  function automatic logic signed [15:0] sat_tc(input logic signed [23:0] v);
    if (v < -24'sd32768) return -16'sd32768;
    if (v > 24'sd32767) return 16'sd32767;
    return v[15:0];
  endfunction

  // coefficient registers
  logic [47:0] temp_q;
  logic [63:0] plow_q;
  logic [63:0] phigh_q;
  logic [15:0] p9_q;
  logic [63:0] hum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q  <= '0;
      plow_q  <= '0;
      phigh_q <= '0;
      p9_q    <= '0;
      hum_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (esc_pkg::cfg_idx_e'(cfg_idx_i))
        esc_pkg::CfgTemp:      temp_q  <= cfg_data_i[47:0];
        esc_pkg::CfgPressLow:  plow_q  <= cfg_data_i;
        esc_pkg::CfgPressHigh: phigh_q <= cfg_data_i;
        esc_pkg::CfgPressNine: p9_q    <= cfg_data_i[15:0];
        esc_pkg::CfgHum:       hum_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic        [7:0]  h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_q[15:0];
  assign t2 = temp_q[31:16];
  assign t3 = temp_q[47:32];
  assign p1 = plow_q[15:0];
  assign p2 = plow_q[31:16];
  assign p3 = plow_q[47:32];
  assign p4 = plow_q[63:48];
  assign p5 = phigh_q[15:0];
  assign p6 = phigh_q[31:16];
  assign p7 = phigh_q[47:32];
  assign p8 = phigh_q[63:48];
  assign p9 = p9_q;
  assign h1 = hum_q[7:0];
  assign h2 = hum_q[23:8];
  assign h3 = hum_q[31:24];
  assign h4 = hum_q[43:32];
  assign h5 = hum_q[55:44];
  assign h6 = hum_q[63:56];

  logic        adv;
  logic [14:1] vld_q;
  logic        out_vld_q;
  logic [87:0] out_data_q;
  logic        div_vld;
  logic [63:0] div_quo;
  esc_pkg::side_t div_side;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[13:11], div_vld, vld_q[9:1], s_axis_tvalid};
      out_vld_q <= vld_q[14];
    end
  end

  // stage registers
  logic        [19:0] rt_s1_q, rp_s1_q, rp_s2_q, rp_s3_q, rp_s4_q, rp_s5_q, rp_s6_q, rp_s7_q;
  logic        [15:0] rh_s1_q, rh_s2_q, rh_s3_q, rh_s4_q;
  logic signed [33:0] v1p_s2_q, dd_s2_q;
  logic signed [22:0] v1s_s3_q;
  logic signed [37:0] tp_s3_q;
  logic signed [20:0] tf_s4_q, tf_s5_q, tf_s6_q, tf_s7_q, tf_s8_q, tf_s9_q, tf_s10_q;
  logic signed [15:0] tc_s5_q, tc_s6_q, tc_s7_q, tc_s8_q, tc_s9_q, tc_s10_q;
  logic signed [43:0] aa_s5_q;
  logic signed [37:0] ap5_s5_q, ap2_s5_q, ap5_s6_q, ap2_s6_q;
  logic signed [35:0] hs_s5_q;
  logic signed [29:0] xh6_s5_q;
  logic signed [30:0] xh3_s5_q;
  logic signed [59:0] b1_s6_q, c3_s6_q, b_s7_q;
  logic signed [20:0] u_s6_q, u_s7_q;
  logic signed [41:0] ab_s6_q;
  logic signed [51:0] as_s7_q;
  logic signed [48:0] ch2_s7_q;
  logic signed [63:0] pa_s8_q, num_s8_q, num_s9_q, num_s10_q;
  logic signed [56:0] uw_s8_q, uw_s9_q, uw_s10_q;
  logic signed [30:0] den_s9_q, den_s10_q;
  logic signed [63:0] sq_s9_q, t_s10_q;

  // stage combinational values
  logic signed [17:0] dt;
  logic signed [16:0] dd;
  logic signed [21:0] pa_a, hx_x, pw;
  logic signed [32:0] hc;
  logic signed [35:0] hw;
  logic signed [31:0] hq;
  logic signed [60:0] nb;

  assign dt   = $signed({1'b0, rt_s1_q[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dd   = $signed({1'b0, rt_s1_q[19:4]}) - $signed({1'b0, t1});
  assign pa_a = 22'(tf_s4_q) - 22'sd128000;
  assign hx_x = 22'(tf_s4_q) - 22'sd76800;
  assign hc   = 33'(ab_s6_q >>> 10) + 33'sd2097152;
  assign pw   = $signed({1'b0, 21'h100000 - {1'b0, rp_s7_q}});
  assign nb   = (61'(pw) <<< 31) - 61'(b_s7_q);
  assign hw   = 36'((50'(ch2_s7_q) + 50'sd8192) >>> 14);
  assign hq   = 32'(uw_s8_q >>> 15);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_s1_q  <= s_axis_tdata[19:0];
      rp_s1_q  <= s_axis_tdata[39:20];
      rh_s1_q  <= s_axis_tdata[55:40];

      v1p_s2_q <= 34'(dt) * 34'(t2);
      dd_s2_q  <= 34'(dd) * 34'(dd);
      rp_s2_q  <= rp_s1_q;
      rh_s2_q  <= rh_s1_q;

      v1s_s3_q <= 23'(v1p_s2_q >>> 11);
      tp_s3_q  <= 38'(dd_s2_q >>> 12) * 38'(t3);
      rp_s3_q  <= rp_s2_q;
      rh_s3_q  <= rh_s2_q;

      tf_s4_q  <= sat_ft(38'(v1s_s3_q) + (tp_s3_q >>> 14));
      rp_s4_q  <= rp_s3_q;
      rh_s4_q  <= rh_s3_q;

      tf_s5_q  <= tf_s4_q;
      tc_s5_q  <= sat_tc((24'(tf_s4_q) * 24'sd5 + 24'sd128) >>> 8);
      aa_s5_q  <= 44'(pa_a) * 44'(pa_a);
      ap5_s5_q <= 38'(pa_a) * 38'(p5);
      ap2_s5_q <= 38'(pa_a) * 38'(p2);
      rp_s5_q  <= rp_s4_q;
      hs_s5_q  <= (36'($signed({1'b0, rh_s4_q})) <<< 14) - (36'(h4) <<< 20)
                  - 36'(h5) * 36'(hx_x) + 36'sd16384;
      xh6_s5_q <= 30'(hx_x) * 30'(h6);
      xh3_s5_q <= 31'(hx_x) * 31'($signed({1'b0, h3}));

      tf_s6_q  <= tf_s5_q;
      tc_s6_q  <= tc_s5_q;
      b1_s6_q  <= 60'(aa_s5_q) * 60'(p6);
      c3_s6_q  <= 60'(aa_s5_q) * 60'(p3);
      ap5_s6_q <= ap5_s5_q;
      ap2_s6_q <= ap2_s5_q;
      rp_s6_q  <= rp_s5_q;
      u_s6_q   <= 21'(hs_s5_q >>> 15);
      ab_s6_q  <= 42'(xh6_s5_q >>> 10) * (42'(xh3_s5_q >>> 11) + 42'sd32768);

      tf_s7_q  <= tf_s6_q;
      tc_s7_q  <= tc_s6_q;
      b_s7_q   <= b1_s6_q + (60'(ap5_s6_q) <<< 17) + (60'(p4) <<< 35);
      as_s7_q  <= 52'(c3_s6_q >>> 8) + (52'(ap2_s6_q) <<< 12) + (52'sd1 <<< 47);
      rp_s7_q  <= rp_s6_q;
      u_s7_q   <= u_s6_q;
      ch2_s7_q <= 49'(hc) * 49'(h2);

      tf_s8_q  <= tf_s7_q;
      tc_s8_q  <= tc_s7_q;
      pa_s8_q  <= 64'(as_s7_q) * 64'($signed({1'b0, p1}));
      num_s8_q <= 64'(nb) * 64'sd3125;
      uw_s8_q  <= 57'(u_s7_q) * 57'(hw);

      tf_s9_q  <= tf_s8_q;
      tc_s9_q  <= tc_s8_q;
      den_s9_q <= pa_s8_q[63:33];
      num_s9_q <= num_s8_q;
      uw_s9_q  <= uw_s8_q;
      sq_s9_q  <= 64'(hq) * 64'(hq);

      tf_s10_q  <= tf_s9_q;
      tc_s10_q  <= tc_s9_q;
      den_s10_q <= den_s9_q;
      num_s10_q <= num_s9_q;
      uw_s10_q  <= uw_s9_q;
      t_s10_q   <= (sq_s9_q >>> 7) * 64'($signed({1'b0, h1}));
    end
  end

  // humidity finish and divider entry
  logic signed [63:0] hfin;
  logic        [16:0] hum_val;
  esc_pkg::side_t     side_in;

  assign hfin = 64'(uw_s10_q) - (t_s10_q >>> 4);

  always_comb begin
    if (hfin < 64'sd0) begin
      hum_val = '0;
    end else if (hfin > HumLimit) begin
      hum_val = HumLimit[28:12];
    end else begin
      hum_val = hfin[28:12];
    end
    side_in.fine_temp = tf_s10_q;
    side_in.temp      = tc_s10_q;
    side_in.hum       = hum_val;
    side_in.zero      = (den_s10_q == '0);
  end

  esc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vld_q[10]),
    .num_i  (num_s10_q),
    .den_i  (den_s10_q),
    .side_i (side_in),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  // pressure finish
  esc_pkg::side_t     side_s11_q, side_s12_q, side_s13_q, side_s14_q;
  logic signed [63:0] p_s11_q, p_s12_q, p_s13_q, m1_s11_q, m2_s11_q, sum_s14_q;
  logic signed [50:0] s_s11_q;
  logic        [63:0] ll_s12_q;
  logic        [31:0] cr_s12_q;
  logic signed [44:0] pa8_s12_q, pa8_s13_q;
  logic signed [38:0] bb_s13_q;
  logic signed [63:0] q_s, sx, pfin;
  logic        [63:0] prod;
  logic        [31:0] press_val;

  assign q_s  = $signed(div_quo);
  assign sx   = 64'(s_s11_q);
  assign prod = ll_s12_q + {cr_s12_q, 32'h0};
  assign pfin = (sum_s14_q >>> 8) + (64'(p7) <<< 4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_s11_q <= div_side;
      p_s11_q    <= q_s;
      s_s11_q    <= 51'(q_s >>> 13);
      m1_s11_q   <= 64'(p9) * (q_s >>> 13);
      m2_s11_q   <= 64'(p8) * q_s;

      side_s12_q <= side_s11_q;
      p_s12_q    <= p_s11_q;
      ll_s12_q   <= 64'(m1_s11_q[31:0]) * 64'(sx[31:0]);
      cr_s12_q   <= 32'(m1_s11_q[31:0] * sx[63:32]) + 32'(m1_s11_q[63:32] * sx[31:0]);
      pa8_s12_q  <= 45'(m2_s11_q >>> 19);

      side_s13_q <= side_s12_q;
      p_s13_q    <= p_s12_q;
      bb_s13_q   <= 39'($signed(prod) >>> 25);
      pa8_s13_q  <= pa8_s12_q;

      side_s14_q <= side_s13_q;
      sum_s14_q  <= p_s13_q + 64'(bb_s13_q) + 64'(pa8_s13_q);

      out_data_q <= {2'b00, side_s14_q.hum, press_val, side_s14_q.temp,
                     side_s14_q.fine_temp};
    end
  end

  always_comb begin
    if (side_s14_q.zero || pfin < 64'sd0) begin
      press_val = '0;
    end else if (pfin > PressLimit) begin
      press_val = 32'hFFFF_FFFF;
    end else begin
      press_val = pfin[31:0];
    end
  end

`ifndef SYNTHESIS
  a_hum_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[85:69] <= 17'd102400))
    else $error("humidity above 100 percent");

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_ready_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");
`endif

endmodule
